### hw/rtl/button_setpoint_editor_assert.svh
// Assertion macros for the button setpoint editor.
// Included by the modules that check their own logic; no other dependencies.
`ifndef BUTTON_SETPOINT_EDITOR_ASSERT_SVH
`define BUTTON_SETPOINT_EDITOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BSE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bse_pkg.sv
// Shared types and constants for the button setpoint editor.
// No dependencies; imported by every module of the block.
package bse_pkg;

  localparam int unsigned NumSetpointsDef = 3;
  localparam int unsigned ModeCountDef    = 4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned ElapsedW  = 16;
  localparam int unsigned IntervalW = 10;
  localparam int unsigned StepW     = 11;
  localparam int unsigned SpW       = 13;

  localparam logic [ElapsedW-1:0] ElapsedSat = '1;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_IDLE_TIMEOUT    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_DELAY    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_INTERVAL = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SETPOINT_STEP   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SETPOINT_MAX    = 3'd4;

  // Reset values of the registers
  localparam logic [ElapsedW-1:0]  IdleTimeoutRst    = 16'd15000;
  localparam logic [ElapsedW-1:0]  RepeatDelayRst    = 16'd2000;
  localparam logic [IntervalW-1:0] RepeatIntervalRst = 10'd20;
  localparam logic [StepW-1:0]     SetpointStepRst   = 11'd16;
  localparam logic [SpW-1:0]       SetpointMaxRst    = 13'd6400;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HOLD   = 2'd1,
    PH_REPEAT = 2'd2
  } bse_phase_e;

  typedef struct packed {
    logic [ElapsedW-1:0]  idle_timeout;
    logic [ElapsedW-1:0]  repeat_delay;
    logic [IntervalW-1:0] repeat_interval;
    logic [StepW-1:0]     setpoint_step;
    logic [SpW-1:0]       setpoint_max;
  } bse_cfg_t;

  typedef struct packed {
    logic menu;
    logic up;
    logic down;
  } bse_keys_t;

  typedef struct packed {
    bse_phase_e phase;
    logic       act;
  } bse_btn_t;

endpackage

### hw/rtl/bse_cfg_regs.sv
// Configuration register file of the button setpoint editor.
// Depends on bse_pkg for the register indexes, widths and reset values.
module bse_cfg_regs
  import bse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [CfgIdxW-1:0]  index_i,
  input  logic [CfgDataW-1:0] data_i,
  output bse_cfg_t            cfg_o
);

  bse_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (index_i)
        CFG_IDLE_TIMEOUT:    cfg_d.idle_timeout    = data_i;
        CFG_REPEAT_DELAY:    cfg_d.repeat_delay    = data_i;
        CFG_REPEAT_INTERVAL: cfg_d.repeat_interval = data_i[IntervalW-1:0];
        CFG_SETPOINT_STEP:   cfg_d.setpoint_step   = data_i[StepW-1:0];
        CFG_SETPOINT_MAX:    cfg_d.setpoint_max    = data_i[SpW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_timeout    <= IdleTimeoutRst;
      cfg_q.repeat_delay    <= RepeatDelayRst;
      cfg_q.repeat_interval <= RepeatIntervalRst;
      cfg_q.setpoint_step   <= SetpointStepRst;
      cfg_q.setpoint_max    <= SetpointMaxRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/bse_btn_step.sv
// Press, hold-delay and auto-repeat decision for one up/down button.
// Depends on bse_pkg for the phase type and widths.
module bse_btn_step
  import bse_pkg::*;
(
  input  bse_phase_e           phase_i,
  input  logic                 pressed_i,
  input  logic [ElapsedW-1:0]  elapsed_i,
  input  logic [ElapsedW-1:0]  delay_i,
  input  logic [IntervalW-1:0] interval_i,
  output bse_btn_t             btn_o
);

  logic delay_hit;
  logic interval_hit;

  assign delay_hit    = elapsed_i >= delay_i;
  assign interval_hit = elapsed_i >= {{(ElapsedW-IntervalW){1'b0}}, interval_i};

  always_comb begin
    btn_o.phase = PH_IDLE;
    btn_o.act   = 1'b0;
    unique case (phase_i)
      PH_IDLE: begin
        if (pressed_i) begin
          btn_o.phase = PH_HOLD;
          btn_o.act   = 1'b1;
        end
      end
      PH_HOLD: begin
        if (pressed_i) begin
          btn_o.phase = delay_hit ? PH_REPEAT : PH_HOLD;
          btn_o.act   = delay_hit;
        end
      end
      PH_REPEAT: begin
        if (pressed_i) begin
          btn_o.phase = PH_REPEAT;
          btn_o.act   = interval_hit;
        end
      end
      default: begin
        btn_o.phase = PH_IDLE;
        btn_o.act   = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/bse_editor_core.sv
// Editor state (row, mode, setpoints, elapsed counter, button phases) and
// its one-tick update. Depends on bse_pkg, bse_btn_step and the assert header.
`include "button_setpoint_editor_assert.svh"

module bse_editor_core
  import bse_pkg::*;
#(
  parameter int unsigned NUM_SETPOINTS = NumSetpointsDef,
  parameter int unsigned MODE_COUNT    = ModeCountDef,
  localparam int unsigned RowW  = $clog2(NUM_SETPOINTS + 2),
  localparam int unsigned ModeW = $clog2(MODE_COUNT)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  bse_keys_t       keys_i,
  input  bse_cfg_t        cfg_i,
  output logic [RowW-1:0]  row_o,
  output logic [ModeW-1:0] mode_o,
  output logic [SpW-1:0]   sp_o [3]
);

  localparam logic [RowW:0]    RowLast = (RowW+1)'(NUM_SETPOINTS + 1);
  localparam logic [ModeW-1:0] ModeTop = ModeW'(MODE_COUNT - 1);

  logic [RowW-1:0]     row_q, row_d, row_a;
  logic [RowW:0]       row_inc;
  logic [ModeW-1:0]    mode_q, mode_d, mode_up;
  logic [SpW-1:0]      sp_q [NUM_SETPOINTS];
  logic [SpW-1:0]      sp_d [NUM_SETPOINTS];
  logic [ElapsedW-1:0] elapsed_q, elapsed_d, e0, e1, e2;
  logic                menu_phase_q, menu_phase_d;
  bse_phase_e          up_phase_q, dn_phase_q;
  bse_btn_t            up_btn, dn_btn;
  logic                timeout;
  logic                menu_press;

  // Tick order: count, idle timeout, menu, up, down
  assign e0      = (elapsed_q != ElapsedSat) ? elapsed_q + 1'b1 : elapsed_q;
  assign timeout = (row_q != '0) && (e0 >= cfg_i.idle_timeout);
  assign row_a   = timeout ? '0 : row_q;

  assign menu_press   = !menu_phase_q && keys_i.menu;
  assign menu_phase_d = menu_press ? 1'b1 : (keys_i.menu ? menu_phase_q : 1'b0);
  assign row_inc      = {1'b0, row_a} + 1'b1;

  always_comb begin
    row_d = row_a;
    if (menu_press) begin
      row_d = (row_inc > RowLast) ? RowW'(1) : row_inc[RowW-1:0];
    end
  end

  assign e1 = menu_press ? '0 : e0;

  bse_btn_step u_up_step (
    .phase_i    (up_phase_q),
    .pressed_i  (keys_i.up),
    .elapsed_i  (e1),
    .delay_i    (cfg_i.repeat_delay),
    .interval_i (cfg_i.repeat_interval),
    .btn_o      (up_btn)
  );

  assign e2 = up_btn.act ? '0 : e1;

  bse_btn_step u_dn_step (
    .phase_i    (dn_phase_q),
    .pressed_i  (keys_i.down),
    .elapsed_i  (e2),
    .delay_i    (cfg_i.repeat_delay),
    .interval_i (cfg_i.repeat_interval),
    .btn_o      (dn_btn)
  );

  assign elapsed_d = dn_btn.act ? '0 : e2;

  // Mode row: up then down, clamped at off and the top mode
  always_comb begin
    mode_up = mode_q;
    if (up_btn.act && (row_d == RowW'(1)) && (mode_q < ModeTop)) begin
      mode_up = mode_q + 1'b1;
    end
    mode_d = mode_up;
    if (dn_btn.act && (row_d == RowW'(1)) && (mode_up != '0)) begin
      mode_d = mode_up - 1'b1;
    end
  end

  // One lane per setpoint: saturating step up, then step down
  for (genvar i = 0; i < NUM_SETPOINTS; i++) begin : g_sp
    logic           sel;
    logic [SpW:0]   sum;
    logic [SpW-1:0] v_up;

    assign sel = (row_d == RowW'(i + 2));
    assign sum = {1'b0, sp_q[i]} + {{(SpW+1-StepW){1'b0}}, cfg_i.setpoint_step};

    always_comb begin
      v_up = sp_q[i];
      if (up_btn.act && sel) begin
        v_up = (sum > {1'b0, cfg_i.setpoint_max}) ? cfg_i.setpoint_max : sum[SpW-1:0];
      end
      sp_d[i] = v_up;
      if (dn_btn.act && sel) begin
        sp_d[i] = (v_up >= {{(SpW-StepW){1'b0}}, cfg_i.setpoint_step}) ?
                  v_up - {{(SpW-StepW){1'b0}}, cfg_i.setpoint_step} : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q        <= '0;
      mode_q       <= '0;
      elapsed_q    <= '0;
      menu_phase_q <= 1'b0;
      up_phase_q   <= PH_IDLE;
      dn_phase_q   <= PH_IDLE;
      for (int k = 0; k < NUM_SETPOINTS; k++) begin
        sp_q[k] <= '0;
      end
    end else if (step_i) begin
      row_q        <= row_d;
      mode_q       <= mode_d;
      elapsed_q    <= elapsed_d;
      menu_phase_q <= menu_phase_d;
      up_phase_q   <= up_btn.phase;
      dn_phase_q   <= dn_btn.phase;
      for (int k = 0; k < NUM_SETPOINTS; k++) begin
        sp_q[k] <= sp_d[k];
      end
    end
  end

  assign row_o  = row_q;
  assign mode_o = mode_q;

  for (genvar j = 0; j < 3; j++) begin : g_sp_out
    if (j < NUM_SETPOINTS) begin : g_live
      assign sp_o[j] = sp_q[j];
    end else begin : g_absent
      assign sp_o[j] = '0;
    end
  end

  `BSE_ASSERT_NEXT(a_idle_holds_state, clk_i, rst_ni, !step_i,
                   $stable(row_q) && $stable(mode_q) && $stable(elapsed_q),
                   "state moved without a tick")
  `BSE_ASSERT_NEXT(a_menu_selects_row, clk_i, rst_ni, step_i && menu_press,
                   (row_q != '0) && (elapsed_q == '0), "menu press left no row selected")
  `BSE_ASSERT_NEXT(a_action_restarts, clk_i, rst_ni, step_i && (up_btn.act || dn_btn.act),
                   elapsed_q == '0, "button action did not restart elapsed count")
  `BSE_ASSERT_NOW(a_timeout_clears, clk_i, rst_ni, timeout && !menu_press, row_d == '0,
                  "idle timeout did not clear the selection")

endmodule

### hw/rtl/button_setpoint_editor.sv
// Button setpoint editor, top level: request pipeline and configuration port.
// Depends on bse_pkg, bse_cfg_regs and bse_editor_core.
//
// Usage
//   Input channel: one request per millisecond tick with the menu, up and
//   down button levels; accepted when in_valid_i is high and in_stall_o low.
//   Output channel: one result per request (selected row, mode, three
//   setpoints) taken when out_valid_o is high and out_stall_i low.
//   Configuration: cfg_index_i selects the register (0 idle timeout,
//   1 repeat delay, 2 repeat interval, 3 setpoint step, 4 setpoint max);
//   written when cfg_valid_i and cfg_ready_o are high. cfg_ready_o is
//   always high. Write only while no request is in flight.
// Timing
//   A request lands in the input register at its accepting edge; once the
//   result register is free, the tick is applied to the editor state and
//   out_valid_o is raised with it. One request per cycle is sustained
//   while the receiver does not stall: the whole tick update is one short
//   combinational pass from the input register into the state registers.
// Reset and stall
//   Reset clears row, mode, setpoints, elapsed count and button phases and
//   loads the register defaults (15000, 2000, 20, 16, 6400).
//   While the receiver stalls, the result and state hold; the input register
//   still takes one more request, then stalls the sender in turn.
module button_setpoint_editor
  import bse_pkg::*;
#(
  parameter int unsigned NUM_SETPOINTS = NumSetpointsDef,
  parameter int unsigned MODE_COUNT    = ModeCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                menu_level_i,
  input  logic                up_level_i,
  input  logic                down_level_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          row_shown_o,
  output logic [1:0]          mode_value_o,
  output logic [SpW-1:0]      setpoint_a_o,
  output logic [SpW-1:0]      setpoint_b_o,
  output logic [SpW-1:0]      setpoint_c_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned RowW  = $clog2(NUM_SETPOINTS + 2);
  localparam int unsigned ModeW = $clog2(MODE_COUNT);

  bse_cfg_t        cfg;
  bse_keys_t       keys_q;
  logic            in_valid_q;
  logic            out_valid_q;
  logic            advance;
  logic            step;
  logic [RowW-1:0]  row;
  logic [ModeW-1:0] mode;
  logic [SpW-1:0]   sp [3];

  // Result register frees when empty or being taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Hold the button levels of the accepted request
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      keys_q.menu <= menu_level_i;
      keys_q.up   <= up_level_i;
      keys_q.down <= down_level_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  bse_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  // The editor state doubles as the result register
  bse_editor_core #(
    .NUM_SETPOINTS (NUM_SETPOINTS),
    .MODE_COUNT    (MODE_COUNT)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .keys_i (keys_q),
    .cfg_i  (cfg),
    .row_o  (row),
    .mode_o (mode),
    .sp_o   (sp)
  );

  assign out_valid_o  = out_valid_q;
  assign row_shown_o  = 3'(row);
  assign mode_value_o = 2'(mode);
  assign setpoint_a_o = sp[0];
  assign setpoint_b_o = sp[1];
  assign setpoint_c_o = sp[2];

endmodule

### dv/button_setpoint_editor_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_setpoint_editor: tick requests and register writes.
// A predictor in this file supplies the expected panels. Depends on bse_pkg and the block's RTL.
module button_setpoint_editor_tb
  import bse_pkg::*;
();

  localparam int unsigned NSP         = NumSetpointsDef;
  localparam int unsigned MODES       = ModeCountDef;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 60;

  // Register settings at both ends of the ranges (interval and step stop short of their top)
  localparam bse_cfg_t WIDE_CFG = '{idle_timeout: 16'd65535, repeat_delay: 16'd65535,
                                    repeat_interval: 10'd1000, setpoint_step: 11'd1024,
                                    setpoint_max: 13'd8191};
  localparam bse_cfg_t TIGHT_CFG = '{idle_timeout: 16'd1, repeat_delay: 16'd1,
                                     repeat_interval: 10'd1, setpoint_step: 11'd1,
                                     setpoint_max: 13'd0};

  // Opening ticks as {menu, up, down}. Press keys with no row selected, walk the mode
  // into its top clamp, press up and down together, pull a setpoint
  // below zero and press all three keys at once.
  localparam logic [2:0] OPENING [24] = '{
    3'b000, 3'b010, 3'b000, 3'b001, 3'b000, 3'b100, 3'b000, 3'b010,
    3'b000, 3'b010, 3'b000, 3'b010, 3'b000, 3'b010, 3'b000, 3'b001,
    3'b011, 3'b000, 3'b100, 3'b000, 3'b001, 3'b010, 3'b111, 3'b000
  };

  typedef struct packed {
    logic [2:0]     row;
    logic [1:0]     mode;
    logic [SpW-1:0] sp_a;
    logic [SpW-1:0] sp_b;
    logic [SpW-1:0] sp_c;
  } panel_t;

  typedef struct packed {
    bse_keys_t keys;
    logic      hold_off;
  } press_t;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                menu_level_i = 1'b0;
  logic                up_level_i   = 1'b0;
  logic                down_level_i = 1'b0;
  logic                out_stall_i  = 1'b0;
  logic                cfg_valid_i  = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i  = CFG_IDLE_TIMEOUT;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [2:0]          row_shown_o;
  logic [1:0]          mode_value_o;
  logic [SpW-1:0]      setpoint_a_o;
  logic [SpW-1:0]      setpoint_b_o;
  logic [SpW-1:0]      setpoint_c_o;
  logic                cfg_ready_o;

  button_setpoint_editor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .menu_level_i (menu_level_i),
    .up_level_i   (up_level_i),
    .down_level_i (down_level_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_shown_o  (row_shown_o),
    .mode_value_o (mode_value_o),
    .setpoint_a_o (setpoint_a_o),
    .setpoint_b_o (setpoint_b_o),
    .setpoint_c_o (setpoint_c_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Traffic shaping and bookkeeping
  press_t      press_q [$];          // requests still to be offered
  panel_t      panel_q [$];          // panels owed by the block, oldest first
  bse_cfg_t    phase_cfg;            // settings that shape the key gestures
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned bad_panels    = 0;
  int unsigned quiet_cycles  = 0;
  logic        req_taken     = 1'b0;
  logic        cfg_hit       = 1'b0;

  // Predicted editor state, starting from the reset values
  bse_cfg_t       model_cfg = '{idle_timeout: IdleTimeoutRst, repeat_delay: RepeatDelayRst,
                                repeat_interval: RepeatIntervalRst,
                                setpoint_step: SetpointStepRst, setpoint_max: SetpointMaxRst};
  logic [2:0]          m_row        = '0;
  logic [1:0]          m_mode       = '0;
  logic [SpW-1:0]      m_sp [3]     = '{default: '0};
  logic [ElapsedW-1:0] m_elapsed    = '0;
  logic                m_menu_held  = 1'b0;
  bse_phase_e          m_up_ph      = PH_IDLE;
  bse_phase_e          m_down_ph    = PH_IDLE;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // One up or down step on whatever row is selected; nothing happens on row none.
  function automatic void nudge(input logic raise);
    logic [SpW:0] v;
    int unsigned  k;
    if (m_row == 3'd1) begin
      if (raise) begin
        if (m_mode < MODES - 1) m_mode = m_mode + 2'd1;
      end else if (m_mode != 2'd0) begin
        m_mode = m_mode - 2'd1;
      end
    end else if (m_row >= 3'd2 && m_row <= NSP + 1) begin
      k = m_row - 3'd2;
      if (raise) begin
        // a setpoint already above the limit is pulled down to it
        v = {1'b0, m_sp[k]} + model_cfg.setpoint_step;
        if (v > model_cfg.setpoint_max) v = model_cfg.setpoint_max;
      end else begin
        v = (m_sp[k] >= model_cfg.setpoint_step) ? m_sp[k] - model_cfg.setpoint_step : '0;
      end
      m_sp[k] = v[SpW-1:0];
    end
  endfunction

  // Press, hold-delay and auto-repeat sequencing of one step key.
  function automatic bse_phase_e run_key(input bse_phase_e ph, input logic pressed,
                                         input logic raise);
    if (!pressed) return PH_IDLE;
    if (ph == PH_IDLE) begin
      nudge(raise);
      m_elapsed = '0;
      return PH_HOLD;
    end
    if (ph == PH_HOLD) begin
      if (m_elapsed < model_cfg.repeat_delay) return PH_HOLD;
      nudge(raise);
      m_elapsed = '0;
      return PH_REPEAT;
    end
    if (m_elapsed >= model_cfg.repeat_interval) begin
      nudge(raise);
      m_elapsed = '0;
    end
    return PH_REPEAT;
  endfunction

  // Apply one millisecond tick and return the panel the block should show after it.
  function automatic panel_t editor_tick(input logic menu, input logic up, input logic down);
    panel_t p;
    if (m_elapsed != ElapsedSat) m_elapsed = m_elapsed + 1'b1;
    if (m_row != 3'd0 && m_elapsed >= model_cfg.idle_timeout) m_row = '0;
    if (!m_menu_held) begin
      if (menu) begin
        m_row = m_row + 3'd1;
        if (m_row > NSP + 1) m_row = 3'd1;
        m_elapsed   = '0;
        m_menu_held = 1'b1;
      end
    end else if (!menu) begin
      m_menu_held = 1'b0;
    end
    m_up_ph   = run_key(m_up_ph, up, 1'b1);
    m_down_ph = run_key(m_down_ph, down, 1'b0);
    p.row  = m_row;
    p.mode = m_mode;
    p.sp_a = m_sp[0];
    p.sp_b = (NSP > 1) ? m_sp[1] : '0;
    p.sp_c = (NSP > 2) ? m_sp[2] : '0;
    return p;
  endfunction

  // Request driver: offer the next tick at the falling edge once the previous one has gone.
  // A request flagged for hold-off waits until every owed panel has been taken.
  always @(negedge clk_i) begin : drive_requests
    press_t nxt;
    logic   give;
    if (rst_ni && (!in_valid_i || req_taken)) begin
      give = press_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
             (!press_q[0].hold_off || panel_q.size() == 0);
      if (give) begin
        nxt = press_q.pop_front();
        menu_level_i <= nxt.keys.menu;
        up_level_i   <= nxt.keys.up;
        down_level_i <= nxt.keys.down;
      end
      in_valid_i <= give;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Monitor: check taken panels, predict accepted requests, track register writes,
  // and end the run when nothing has moved for too long.
  always @(posedge clk_i) begin : watch_block
    panel_t got;
    panel_t want;
    logic   moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        got = '{row: row_shown_o, mode: mode_value_o, sp_a: setpoint_a_o,
                sp_b: setpoint_b_o, sp_c: setpoint_c_o};
        if (panel_q.size() == 0) begin
          bad_panels++;
          if (bad_panels <= 10)
            $display("%0t: panel with no request behind it: row %0d mode %0d", $time,
                     got.row, got.mode);
        end else begin
          want = panel_q.pop_front();
          if (got !== want) begin
            bad_panels++;
            if (bad_panels <= 10)
              $display("%0t: panel mismatch (got/want)", $time,
                       " row %0d/%0d mode %0d/%0d", got.row, want.row, got.mode, want.mode,
                       " a %0d/%0d b %0d/%0d c %0d/%0d", got.sp_a, want.sp_a,
                       got.sp_b, want.sp_b, got.sp_c, want.sp_c);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        panel_q.push_back(editor_tick(menu_level_i, up_level_i, down_level_i));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        case (cfg_index_i)
          CFG_IDLE_TIMEOUT:    model_cfg.idle_timeout    = cfg_data_i;
          CFG_REPEAT_DELAY:    model_cfg.repeat_delay    = cfg_data_i;
          CFG_REPEAT_INTERVAL: model_cfg.repeat_interval = cfg_data_i[IntervalW-1:0];
          CFG_SETPOINT_STEP:   model_cfg.setpoint_step   = cfg_data_i[StepW-1:0];
          CFG_SETPOINT_MAX:    model_cfg.setpoint_max    = cfg_data_i[SpW-1:0];
          default: ;
        endcase
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
    req_taken <= rst_ni && in_valid_i && !in_stall_o;
    cfg_hit   <= rst_ni && cfg_valid_i && cfg_ready_o;
  end

  task automatic push_keys(input bse_keys_t k, input int unsigned n);
    repeat (n) press_q.push_back('{keys: k, hold_off: 1'b0});
  endtask

  // Wait until every request has gone in and every panel has come out.
  task automatic settle();
    do @(posedge clk_i); while (press_q.size() != 0 || in_valid_i || panel_q.size() != 0);
  endtask

  // Write all five registers back to back, holding valid across the writes.
  task automatic load_settings(input bse_cfg_t s);
    logic [CfgIdxW-1:0]  regs [5];
    logic [CfgDataW-1:0] vals [5];
    regs = '{CFG_IDLE_TIMEOUT, CFG_REPEAT_DELAY, CFG_REPEAT_INTERVAL, CFG_SETPOINT_STEP,
             CFG_SETPOINT_MAX};
    vals = '{s.idle_timeout, s.repeat_delay, CfgDataW'(s.repeat_interval),
             CfgDataW'(s.setpoint_step), CfgDataW'(s.setpoint_max)};
    phase_cfg = s;
    @(negedge clk_i);
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      do @(negedge clk_i); while (!cfg_hit);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Short timings so that holds reach auto-repeat and idle gaps reach the timeout.
  function automatic bse_cfg_t pick_settings();
    bse_cfg_t s;
    s.idle_timeout    = ElapsedW'($urandom_range(2, 60));
    s.repeat_delay    = ElapsedW'($urandom_range(1, 12));
    s.repeat_interval = IntervalW'($urandom_range(1, 6));
    case ($urandom_range(0, 3))
      0:       s.setpoint_step = 11'd1;
      1:       s.setpoint_step = 11'd1024;
      default: s.setpoint_step = StepW'($urandom_range(2, 1023));
    endcase
    case ($urandom_range(0, 3))
      0:       s.setpoint_max = 13'd8191;
      default: s.setpoint_max = SpW'($urandom_range(1, 8190));
    endcase
    return s;
  endfunction

  // One key gesture: mostly clean presses and holds with random timing, some noise.
  task automatic add_gesture();
    bse_keys_t   k;
    int unsigned dwell;
    k = '0;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        k.menu = 1'b1;
        k.up   = ($urandom_range(0, 5) == 0);
        push_keys(k, $urandom_range(1, 3));
        push_keys('0, $urandom_range(1, 2));
      end
      3, 4, 5, 6: begin
        case ($urandom_range(0, 4))
          0, 1:    k.up   = 1'b1;
          2, 3:    k.down = 1'b1;
          default: {k.up, k.down} = 2'b11;
        endcase
        // either a tap or a hold that runs into the repeat steps
        if ($urandom_range(0, 1) == 0)
          dwell = $urandom_range(1, 3);
        else
          dwell = phase_cfg.repeat_delay + phase_cfg.repeat_interval * $urandom_range(0, 5) +
                  $urandom_range(0, 2);
        push_keys(k, (dwell > 80) ? 80 : dwell);
        push_keys('0, $urandom_range(1, 3));
      end
      7: begin
        dwell = phase_cfg.idle_timeout + 3;
        push_keys('0, $urandom_range(1, (dwell > 80) ? 80 : dwell));
      end
      default: repeat ($urandom_range(1, 6)) push_keys(bse_keys_t'($urandom_range(0, 7)), 1);
    endcase
  endtask

  task automatic run_phase(input bse_cfg_t s, input int unsigned send_pct,
                           input int unsigned hold_pct, input int unsigned count);
    settle();
    load_settings(s);
    send_idle_pct = send_pct;
    stall_pct     = hold_pct;
    while (press_q.size() < count) add_gesture();
    // stop the sender half way until the pipeline has emptied
    press_q[press_q.size() / 2].hold_off = 1'b1;
  endtask

  initial begin
    phase_cfg = model_cfg;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Opening ticks at the reset settings, full rate
    for (int i = 0; i < 24; i++) push_keys(bse_keys_t'(OPENING[i]), 1);

    // Short run with the widest settings: idle a while, step the menu on to the mode row,
    // then hold up well inside the longest hold delay so only the first step lands.
    settle();
    load_settings(WIDE_CFG);
    push_keys('0, LONG_HOLD);
    push_keys(bse_keys_t'(3'b100), 1);
    push_keys('0, 1);
    push_keys(bse_keys_t'(3'b100), 1);
    push_keys('0, 1);
    push_keys(bse_keys_t'(3'b010), LONG_HOLD);
    push_keys('0, 5);

    // Narrowest settings, then random ones, rotating through the idling patterns
    run_phase(TIGHT_CFG, 87, 0, 220);
    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0:       run_phase(pick_settings(), 0, 0, 220);
        1:       run_phase(pick_settings(), 87, 0, 220);
        2:       run_phase(pick_settings(), 0, 87, 220);
        default: run_phase(pick_settings(), 10, 10, 220);
      endcase
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (bad_panels == 0 && panel_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
